### rtl/sosl_pkg.sv
// Shared types and constants for the self-organizing search list.
// Used by sosl_ctrl, sosl_dp, the top level and the port checker.
package sosl_pkg;

  // List geometry
  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned KEY_W = 32;
  localparam int unsigned POS_W = 4;
  localparam int unsigned CMD_W = 2;
  localparam int unsigned ST_W  = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_APPEND    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MTF       = 2'd2;
  localparam logic [CMD_W-1:0] CMD_TRANSPOSE = 2'd3;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_MISS = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;

  // Kind of result the controller asks the datapath to report
  typedef enum logic [1:0] {
    REPLY_APPEND,
    REPLY_FULL,
    REPLY_MISS,
    REPLY_HIT
  } reply_e;

  // Controller to datapath commands
  typedef struct packed {
    logic   load;         // capture cmd/key, restart the scan
    logic   scan;         // issue next scan read, advance compare stage
    logic   append;       // write key at the tail, bump the count
    logic   shift_start;  // capture hit entry, set up the reorder sweep
    logic   shift;        // one step of the reorder sweep
    logic   place;        // write the held entry at its new slot
    logic   emit;         // load the result registers
    reply_e reply;
  } sosl_ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_append;
    logic full;
    logic empty;
    logic hit;
    logic last;
    logic reorder;
    logic shift_flush;
  } sosl_stat_t;

endpackage

### rtl/self_organizing_search_list.sv
// Self-organizing search list: a bounded list of 32-bit values with
// move-to-front and transpose searches.
// Depends on sosl_pkg, sosl_ctrl and sosl_dp.
//
// Usage: drive cmd_i and key_value_i with start_i high; the command is
// taken at a clock edge where busy_o is low. One result per command comes
// back as a one-cycle pulse on valid_o with found_o, position_o and
// status_o; the receiver must take it, there is no back-pressure.
// An append or a full refusal is answered without a scan. A search
// matching at position k is answered when the compare stage reaches it,
// a miss when it reaches the last entry (an empty list is not scanned).
// Reordering keeps busy_o high after the result: move-to-front shifts
// the k entries ahead of the match up one slot, transpose shifts one,
// then the held entry is placed. The entry memory has one read and one
// write port: the scan checks one entry per cycle, the sweep moves one.
// A new command may be taken in the cycle the previous result is shown.
// Reset empties the list (fill count zero); entry contents are not cleared.
module self_organizing_search_list (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [sosl_pkg::CMD_W-1:0]        cmd_i,
  input  logic signed [sosl_pkg::KEY_W-1:0] key_value_i,
  output logic                              valid_o,
  output logic                              found_o,
  output logic [sosl_pkg::POS_W-1:0]        position_o,
  output logic [sosl_pkg::ST_W-1:0]         status_o
);

  sosl_pkg::sosl_ctrl_t ctrl;
  sosl_pkg::sosl_stat_t stat;

  sosl_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .busy_o  (busy_o)
  );

  sosl_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .key_value_i (key_value_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .valid_o     (valid_o),
    .found_o     (found_o),
    .position_o  (position_o),
    .status_o    (status_o)
  );

endmodule

### rtl/sosl_dp.sv
// Datapath of the self-organizing search list: entry memory, fill count,
// scan compare pipeline, reorder sweep and result registers. Uses sosl_pkg.
module sosl_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [sosl_pkg::CMD_W-1:0]       cmd_i,
  input  logic signed [sosl_pkg::KEY_W-1:0] key_value_i,
  input  sosl_pkg::sosl_ctrl_t             ctrl_i,
  output sosl_pkg::sosl_stat_t             stat_o,
  output logic                             valid_o,
  output logic                             found_o,
  output logic [sosl_pkg::POS_W-1:0]       position_o,
  output logic [sosl_pkg::ST_W-1:0]        status_o
);

  localparam int unsigned IDX_W = sosl_pkg::IDX_W;
  localparam int unsigned CNT_W = sosl_pkg::CNT_W;
  localparam int unsigned KEY_W = sosl_pkg::KEY_W;

  // Entry memory, one write and one registered read per cycle
  logic [KEY_W-1:0] mem_q [sosl_pkg::DEPTH];
  logic [KEY_W-1:0] rdata_q;
  logic [IDX_W-1:0] rd_addr;
  logic             we;
  logic [IDX_W-1:0] wr_addr;
  logic [KEY_W-1:0] wr_data;

  // Item and list state
  logic [sosl_pkg::CMD_W-1:0] cmd_q;
  logic [KEY_W-1:0]           key_q;
  logic [CNT_W-1:0]           count_q, count_d;

  // Scan pipeline
  logic [CNT_W-1:0] rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic             cmp_v_q, cmp_v_d;
  logic             rd_issue;

  // Reorder sweep
  logic [KEY_W-1:0] hold_q;
  logic [IDX_W-1:0] sh_idx_q, sh_idx_d;
  logic [IDX_W-1:0] sh_wa_q, sh_wa_d;
  logic [IDX_W-1:0] stop_q;
  logic             sh_rd_q, sh_rd_d;
  logic             sh_wv_q, sh_wv_d;

  // Results
  logic                       res_v_q;
  logic                       found_q;
  logic [sosl_pkg::POS_W-1:0] pos_q;
  logic [sosl_pkg::ST_W-1:0]  st_q;

  logic hit;

  // Status toward the controller
  assign hit = cmp_v_q && (rdata_q == key_q);
  assign rd_issue = rd_idx_q < count_q;

  always_comb begin
    stat_o.is_append   = (cmd_q == sosl_pkg::CMD_APPEND);
    stat_o.full        = (count_q == CNT_W'(sosl_pkg::DEPTH));
    stat_o.empty       = (count_q == '0);
    stat_o.hit         = hit;
    stat_o.last        = cmp_v_q && ((CNT_W'(cmp_idx_q) + CNT_W'(1)) == count_q);
    stat_o.reorder     = hit && (cmp_idx_q != '0) &&
                         ((cmd_q == sosl_pkg::CMD_MTF) || (cmd_q == sosl_pkg::CMD_TRANSPOSE));
    stat_o.shift_flush = sh_wv_q && !sh_rd_q;
  end

  // Memory port selection
  always_comb begin
    rd_addr = ctrl_i.shift ? sh_idx_q : rd_idx_q[IDX_W-1:0];
    we      = 1'b0;
    wr_addr = sh_wa_q;
    wr_data = rdata_q;
    if (ctrl_i.append) begin
      we      = 1'b1;
      wr_addr = count_q[IDX_W-1:0];
      wr_data = key_q;
    end else if (ctrl_i.shift && sh_wv_q) begin
      we = 1'b1;
    end else if (ctrl_i.place) begin
      we      = 1'b1;
      wr_addr = stop_q;
      wr_data = hold_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

  // Scan and sweep next-state
  always_comb begin
    rd_idx_d  = rd_idx_q;
    cmp_idx_d = cmp_idx_q;
    cmp_v_d   = cmp_v_q;
    count_d   = count_q;
    sh_idx_d  = sh_idx_q;
    sh_wa_d   = sh_wa_q;
    sh_rd_d   = sh_rd_q;
    sh_wv_d   = sh_wv_q;
    if (ctrl_i.load) begin
      rd_idx_d = '0;
      cmp_v_d  = 1'b0;
    end else if (ctrl_i.scan) begin
      cmp_v_d = rd_issue;
      if (rd_issue) begin
        cmp_idx_d = rd_idx_q[IDX_W-1:0];
        rd_idx_d  = rd_idx_q + CNT_W'(1);
      end
    end
    if (ctrl_i.append) begin
      count_d = count_q + CNT_W'(1);
    end
    if (ctrl_i.shift_start) begin
      sh_idx_d = cmp_idx_q - IDX_W'(1);
      sh_rd_d  = 1'b1;
      sh_wv_d  = 1'b0;
    end else if (ctrl_i.shift) begin
      // read one slot lower, write it one slot up on the next cycle
      sh_wv_d = sh_rd_q;
      sh_wa_d = sh_idx_q + IDX_W'(1);
      if (sh_rd_q) begin
        if (sh_idx_q == stop_q) begin
          sh_rd_d = 1'b0;
        end else begin
          sh_idx_d = sh_idx_q - IDX_W'(1);
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rd_idx_q <= '0;
      cmp_v_q  <= 1'b0;
      sh_rd_q  <= 1'b0;
      sh_wv_q  <= 1'b0;
      res_v_q  <= 1'b0;
    end else begin
      count_q  <= count_d;
      rd_idx_q <= rd_idx_d;
      cmp_v_q  <= cmp_v_d;
      sh_rd_q  <= sh_rd_d;
      sh_wv_q  <= sh_wv_d;
      res_v_q  <= ctrl_i.emit;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    sh_idx_q  <= sh_idx_d;
    sh_wa_q   <= sh_wa_d;
    if (ctrl_i.load) begin
      cmd_q <= cmd_i;
      key_q <= key_value_i;
    end
    if (ctrl_i.shift_start) begin
      hold_q <= rdata_q;
      stop_q <= (cmd_q == sosl_pkg::CMD_MTF) ? '0 : (cmp_idx_q - IDX_W'(1));
    end
    if (ctrl_i.emit) begin
      unique case (ctrl_i.reply)
        sosl_pkg::REPLY_APPEND: begin
          found_q <= 1'b0;
          pos_q   <= sosl_pkg::POS_W'(count_q);
          st_q    <= sosl_pkg::ST_OK;
        end
        sosl_pkg::REPLY_FULL: begin
          found_q <= 1'b0;
          pos_q   <= '0;
          st_q    <= sosl_pkg::ST_FULL;
        end
        sosl_pkg::REPLY_MISS: begin
          found_q <= 1'b0;
          pos_q   <= '0;
          st_q    <= sosl_pkg::ST_MISS;
        end
        sosl_pkg::REPLY_HIT: begin
          found_q <= 1'b1;
          pos_q   <= sosl_pkg::POS_W'(cmp_idx_q);
          st_q    <= sosl_pkg::ST_OK;
        end
        default: begin
          found_q <= 1'b0;
          pos_q   <= '0;
          st_q    <= sosl_pkg::ST_MISS;
        end
      endcase
    end
  end

  assign valid_o    = res_v_q;
  assign found_o    = found_q;
  assign position_o = pos_q;
  assign status_o   = st_q;

endmodule

### rtl/sosl_ctrl.sv
// Controller of the self-organizing search list: sequences accept, scan,
// reorder sweep and final placement. Uses sosl_pkg types.
module sosl_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  sosl_pkg::sosl_stat_t stat_i,
  output sosl_pkg::sosl_ctrl_t ctrl_o,
  output logic                 busy_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_PLACE = 2'd3;

  logic [1:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d            = state_q;
    ctrl_o             = '0;
    ctrl_o.reply       = sosl_pkg::REPLY_MISS;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctrl_o.load = 1'b1;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        ctrl_o.scan = 1'b1;
        if (stat_i.is_append) begin
          ctrl_o.emit = 1'b1;
          state_d     = S_IDLE;
          if (stat_i.full) begin
            ctrl_o.reply = sosl_pkg::REPLY_FULL;
          end else begin
            ctrl_o.append = 1'b1;
            ctrl_o.reply  = sosl_pkg::REPLY_APPEND;
          end
        end else if (stat_i.empty) begin
          ctrl_o.emit = 1'b1;
          state_d     = S_IDLE;
        end else if (stat_i.hit) begin
          ctrl_o.emit  = 1'b1;
          ctrl_o.reply = sosl_pkg::REPLY_HIT;
          if (stat_i.reorder) begin
            ctrl_o.shift_start = 1'b1;
            state_d            = S_SHIFT;
          end else begin
            state_d = S_IDLE;
          end
        end else if (stat_i.last) begin
          ctrl_o.emit = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_SHIFT: begin
        ctrl_o.shift = 1'b1;
        if (stat_i.shift_flush) begin
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        ctrl_o.place = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

### rtl/sosl_checker.sv
// Port-level checks for the self-organizing search list, bound to the top.
// Uses sosl_pkg status codes.
module sosl_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start_i,
  input logic                              busy_o,
  input logic                              valid_o,
  input logic                              found_o,
  input logic [sosl_pkg::POS_W-1:0]        position_o,
  input logic [sosl_pkg::ST_W-1:0]         status_o
);

  // An accepted command makes the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted command did not raise busy");

  // A result only follows a cycle of work
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy_o))
    else $error("result without preceding work");

  // Results are isolated pulses
  a_single_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("back-to-back result pulses");

  // Refusals and misses carry no match and position zero
  a_fail_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (status_o != sosl_pkg::ST_OK)) |-> (!found_o && (position_o == '0)))
    else $error("failed command reports a match or position");

  // A match always reports ok
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && found_o) |-> (status_o == sosl_pkg::ST_OK))
    else $error("match reported with bad status");

endmodule

bind self_organizing_search_list sosl_checker u_sosl_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .valid_o    (valid_o),
  .found_o    (found_o),
  .position_o (position_o),
  .status_o   (status_o)
);

### dv/self_organizing_search_list_checker.sv
// Result checker for the self-organizing search list: tracks command transfers,
// predicts each reply from its own copy of the list, and compares replies.
// Depends on sosl_pkg for widths and command/status codes.
module self_organizing_search_list_checker
  import sosl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  logic [CMD_W-1:0] cmd_i,
  input  logic [KEY_W-1:0] key_i,
  input  logic             valid_i,
  input  logic             found_i,
  input  logic [POS_W-1:0] position_i,
  input  logic [ST_W-1:0]  status_i,
  output int               err_count_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic [ST_W-1:0]  status;
  } lookup_reply_t;

  // Shadow list, front first, and its fill count
  logic [KEY_W-1:0] shadow_list [DEPTH];
  int unsigned      shadow_fill;

  lookup_reply_t    pending_replies [$];
  int               err_total;

  // Apply one command to the shadow list and return the reply it should give
  function automatic lookup_reply_t predict_list_op(input logic [CMD_W-1:0] op,
                                                    input logic [KEY_W-1:0] key);
    lookup_reply_t    r;
    int               hit;
    logic [KEY_W-1:0] held;
    r   = '0;
    hit = -1;
    if (op == CMD_APPEND) begin
      if (shadow_fill >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        shadow_list[shadow_fill] = key;
        r.position = POS_W'(shadow_fill);
        r.status   = ST_OK;
        shadow_fill++;
      end
    end else begin
      // first match from the front
      for (int i = 0; i < int'(shadow_fill); i++) begin
        if (hit < 0 && shadow_list[i] == key) hit = i;
      end
      if (hit < 0) begin
        r.status = ST_MISS;
      end else begin
        r.found    = 1'b1;
        r.position = POS_W'(hit);
        r.status   = ST_OK;
        held       = shadow_list[hit];
        if (op == CMD_MTF) begin
          for (int i = hit; i > 0; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[0] = held;
        end else if (op == CMD_TRANSPOSE && hit > 0) begin
          shadow_list[hit]   = shadow_list[hit-1];
          shadow_list[hit-1] = held;
        end
      end
    end
    return r;
  endfunction

  // Replies are checked before the same-edge transfer is predicted, so order holds
  always @(posedge clk_i or negedge rst_ni) begin : reply_check
    lookup_reply_t want;
    if (!rst_ni) begin
      shadow_fill = 0;
      pending_replies.delete();
      err_total   = 0;
      err_count_o <= 0;
      pending_o   <= 0;
    end else begin
      if (valid_i) begin
        if (pending_replies.size() == 0) begin
          err_total++;
          if (err_total <= 10)
            $display("%0t: reply with none outstanding: found=%0d position=%0d status=%0d",
                     $realtime, found_i, position_i, status_i);
        end else begin
          want = pending_replies.pop_front();
          if (found_i !== want.found || position_i !== want.position ||
              status_i !== want.status) begin
            err_total++;
            if (err_total <= 10)
              $display("%0t: reply mismatch: expected found=%0d position=%0d status=%0d, got found=%0d position=%0d status=%0d",
                       $realtime, want.found, want.position, want.status,
                       found_i, position_i, status_i);
          end
        end
      end
      if (start_i && !busy_i) pending_replies.push_back(predict_list_op(cmd_i, key_i));
      err_count_o <= err_total;
      pending_o   <= pending_replies.size();
    end
  end

endmodule

### dv/self_organizing_search_list_tb.sv
// Testbench top for the self-organizing search list: clock, reset, command
// stimulus in bursts, watchdog and verdict.
// Depends on sosl_pkg, the block and self_organizing_search_list_checker.
module self_organizing_search_list_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sosl_pkg::*;

  localparam int RANDOM_OPS     = 1600;
  localparam int IDLE_LIMIT     = 1000;
  localparam int DRAIN_CYCLES   = 40;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start_i;
  logic                    busy_o;
  logic [CMD_W-1:0]        cmd_i;
  logic signed [KEY_W-1:0] key_value_i;
  logic                    valid_o;
  logic                    found_o;
  logic [POS_W-1:0]        position_o;
  logic [ST_W-1:0]         status_o;

  int err_count;
  int pending_count;

  // Values known to be in the list (order not tracked; only used to pick hits)
  logic [KEY_W-1:0] stored_vals [$];
  int               burst_left;
  int               idle_cycles;

  self_organizing_search_list uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .cmd_i       (cmd_i),
    .key_value_i (key_value_i),
    .valid_o     (valid_o),
    .found_o     (found_o),
    .position_o  (position_o),
    .status_o    (status_o)
  );

  self_organizing_search_list_checker u_result_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_i      (busy_o),
    .cmd_i       (cmd_i),
    .key_i       (key_value_i),
    .valid_i     (valid_o),
    .found_i     (found_o),
    .position_i  (position_o),
    .status_i    (status_o),
    .err_count_o (err_count),
    .pending_o   (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: cycles with neither a command transfer nor a reply
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || valid_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

  // One command transfer; opens a gap between bursts when the burst runs out
  task automatic send_op(input logic [CMD_W-1:0] op, input logic [KEY_W-1:0] key);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    start_i     <= 1'b1;
    cmd_i       <= op;
    key_value_i <= key;
    do @(posedge clk_i); while (busy_o);
    if (op == CMD_APPEND && stored_vals.size() < DEPTH) stored_vals.push_back(key);
  endtask

  // Hold off until every outstanding reply has come back
  task automatic drain_replies();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
  endtask

  function automatic logic [CMD_W-1:0] pick_search_op();
    case ($urandom_range(0, 2))
      0:       return CMD_SEARCH;
      1:       return CMD_MTF;
      default: return CMD_TRANSPOSE;
    endcase
  endfunction

  initial begin
    int               dice;
    logic [KEY_W-1:0] key;
    start_i     <= 1'b0;
    cmd_i       <= CMD_APPEND;
    key_value_i <= '0;
    rst_ni      <= 1'b0;
    burst_left  = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every search kind on an empty list
    send_op(CMD_SEARCH, 32'h0000_0005);
    send_op(CMD_MTF, 32'h0000_0005);
    send_op(CMD_TRANSPOSE, 32'h0000_0005);
    // extreme values, with a duplicate to check first-match
    send_op(CMD_APPEND, 32'h7FFF_FFFF);
    send_op(CMD_APPEND, 32'h8000_0000);
    send_op(CMD_APPEND, 32'h0000_0000);
    send_op(CMD_APPEND, 32'hFFFF_FFFF);
    send_op(CMD_APPEND, 32'h8000_0000);
    send_op(CMD_SEARCH, 32'h8000_0000);
    // match at front leaves order alone
    send_op(CMD_MTF, 32'h7FFF_FFFF);
    send_op(CMD_TRANSPOSE, 32'h7FFF_FFFF);
    // deep move-to-front, then a swap
    send_op(CMD_MTF, 32'hFFFF_FFFF);
    send_op(CMD_TRANSPOSE, 32'h8000_0000);
    send_op(CMD_MTF, 32'h1234_5678);
    // fill to capacity, then one refused append
    while (stored_vals.size() < DEPTH) send_op(CMD_APPEND, $urandom);
    send_op(CMD_APPEND, $urandom);
    // tail entry to the front, then swap the new tail
    send_op(CMD_MTF, stored_vals[DEPTH-1]);
    send_op(CMD_TRANSPOSE, stored_vals[DEPTH-2]);
    drain_replies();

    // Random: mostly hits, some misses and appends (refused once full)
    for (int n = 0; n < RANDOM_OPS; n++) begin
      dice = $urandom_range(0, 99);
      if (dice < 12) begin
        key = ($urandom_range(0, 3) == 0 && stored_vals.size() > 0) ?
              stored_vals[$urandom_range(0, stored_vals.size() - 1)] : $urandom;
        send_op(CMD_APPEND, key);
      end else if (dice < 27 || stored_vals.size() == 0) begin
        send_op(pick_search_op(), $urandom);
      end else begin
        send_op(pick_search_op(), stored_vals[$urandom_range(0, stored_vals.size() - 1)]);
      end
      if (n % 256 == 255) drain_replies();
    end

    // Wind down: wait out outstanding replies, then a few quiet cycles
    drain_replies();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
